// ===== rtl/core/pffa_pkg.sv =====
// Package: constants, status codes and cell types for the paged first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package pffa_pkg;
  localparam int MaxPages = 256;
  localparam int PgW = $clog2(MaxPages + 1);
  localparam int IdxW = $clog2(MaxPages);
  localparam int CfgW = 5;
  localparam int NbW = 24;
  localparam int AddrW = 25;
  localparam int OutW = 16;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_MEM = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [PgW-1:0] start;
    logic [PgW-1:0] pages;
  } blk_t;

  // page index to byte address, full width
  function automatic logic [PgW+31:0] page_addr_full(input logic [PgW-1:0] pg,
                                                     input logic [CfgW-1:0] sh);
    return {{32{1'b0}}, pg} << sh;
  endfunction

  // page index to byte address, truncated to the address width
  function automatic logic [AddrW-1:0] page_addr(input logic [PgW-1:0] pg,
                                                 input logic [CfgW-1:0] sh);
    logic [PgW+31:0] w;
    w = page_addr_full(pg, sh);
    return w[AddrW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pffa_cell.sv =====
// One list cell: holds an entry, loads a new one, and shifts toward its lower neighbor.
`timescale 1ns / 1ps
`default_nettype none
module pffa_cell (
  input  wire logic          clk_i,
  input  wire logic          load_i,
  input  wire pffa_pkg::blk_t load_data_i,
  input  wire logic          shift_i,
  input  wire pffa_pkg::blk_t upper_i,
  output pffa_pkg::blk_t     data_o
);
  import pffa_pkg::*;
  blk_t data_q;
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= upper_i;
    end
  end
  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== rtl/core/pffa_chain.sv =====
// Row of list cells with a rotating scan head at cell 0.
`timescale 1ns / 1ps
`default_nettype none
module pffa_chain (
  input  wire logic           clk_i,
  input  wire logic           rot_i,
  input  wire logic           drop_i,
  input  wire logic [pffa_pkg::IdxW-1:0] drop_idx_i,
  input  wire logic           wr_i,
  input  wire logic [pffa_pkg::IdxW-1:0] wr_idx_i,
  input  wire pffa_pkg::blk_t wr_data_i,
  output pffa_pkg::blk_t      head_o
);
  import pffa_pkg::*;
  // Rotate: cell k takes cell k+1, last cell takes the head.
  // Drop: cells at and above the dropped index take their upper neighbor.
  blk_t cells [MaxPages];
  blk_t feed [MaxPages];
  for (genvar k = 0; k < MaxPages; k++) begin : g_cell
    if (k == MaxPages - 1) begin : g_last
      assign feed[k] = cells[0];
    end else begin : g_mid
      assign feed[k] = cells[k+1];
    end
    pffa_cell u_cell (
      .clk_i,
      .load_i(wr_i && wr_idx_i == IdxW'(k)),
      .load_data_i(wr_data_i),
      .shift_i(rot_i || (drop_i && IdxW'(k) >= drop_idx_i)),
      .upper_i(feed[k]),
      .data_o(cells[k])
    );
  end
  assign head_o = cells[0];
endmodule
`default_nettype wire

// ===== rtl/core/paged_first_fit_allocator.sv =====
// Top level: command sequencer over the free-list and address-map cell chains.
`timescale 1ns / 1ps
`default_nettype none
// Paged first-fit allocator. An allocation is served by rotating the free
// list and, if no free entry fits, then the address map; a free rotates only
// the address map. Both are rows of 256 cells rotated through a head cell one
// entry per cycle; every row that is searched turns one full lap, so order is
// kept. A taken free entry is removed in the commit cycle by shifting the
// entries above it down one cell. The result sits in an output register; the
// next request is accepted the cycle after it is taken.
module paged_first_fit_allocator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [pffa_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic cmd_i,
  input  wire logic [pffa_pkg::NbW-1:0] num_bytes_i,
  input  wire logic [pffa_pkg::AddrW-1:0] byte_address_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [1:0] status_o,
  output logic [pffa_pkg::AddrW-1:0] block_offset_o,
  output logic [pffa_pkg::PgW-1:0] start_page_o,
  output logic [pffa_pkg::PgW-1:0] pages_granted_o,
  output logic signed [pffa_pkg::OutW-1:0] outstanding_o
);
  import pffa_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0, S_FSCAN = 2'd1, S_MSCAN = 2'd2, S_DONE = 2'd3;

  logic [1:0] st_q, st_d;
  logic [CfgW-1:0] psl_q;
  logic [PgW-1:0] fcnt_q, mcnt_q, hw_q;
  logic [OutW-1:0] outst_q;
  logic ov_q;
  status_e rs_q;
  blk_t rb_q;
  logic [AddrW-1:0] roff_q;

  logic cmd_q;
  logic [PgW-1:0] npg_q;
  logic [AddrW-1:0] addr_q;
  logic [IdxW-1:0] i_q;
  logic ffound_q, mfound_q;
  logic [IdxW-1:0] fslot_q, mslot_q;
  blk_t fhit_q, mhit_q;

  blk_t fhead, mhead;
  logic [NbW-1:0] nb_sh;
  logic nb_rem;
  logic [NbW:0] npg_full;
  logic [PgW-1:0] npg_in;
  logic [PgW+31:0] m_key;
  logic [PgW:0] hw_sum;
  logic acc, last, done, f_fit, m_hit;
  status_e res_st;
  blk_t res_blk;
  logic f_wr, f_drop, m_wr;
  logic [IdxW-1:0] m_idx;

  // page count of request: ceil(nb / 2^sh), saturated past the pool
  always_comb begin
    nb_sh = num_bytes_i >> psl_q;
    nb_rem = |(num_bytes_i & ~({NbW{1'b1}} << psl_q));
    npg_full = {1'b0, nb_sh} + {{NbW{1'b0}}, nb_rem};
    npg_in = (npg_full > (NbW+1)'(MaxPages)) ? '1 : npg_full[PgW-1:0];
  end

  assign in_stall_o = (st_q != S_IDLE) || ov_q;
  assign cfg_ready_o = (st_q == S_IDLE) && !ov_q;
  assign acc = in_valid_i && !in_stall_o;
  assign last = (i_q == '1);
  assign done = (st_q == S_DONE);
  assign f_fit = (st_q == S_FSCAN) && ({1'b0, i_q} < fcnt_q) && !ffound_q &&
                 (fhead.pages >= npg_q);
  assign m_key = cmd_q ? {{(PgW+32-AddrW){1'b0}}, addr_q} : page_addr_full(hw_q, psl_q);
  assign m_hit = (st_q == S_MSCAN) && ({1'b0, i_q} < mcnt_q) && !mfound_q &&
                 (page_addr_full(mhead.start, psl_q) == m_key);
  assign hw_sum = {1'b0, hw_q} + {1'b0, npg_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (acc) st_d = cmd_i ? S_MSCAN : S_FSCAN;
      S_FSCAN: if (last) st_d = (ffound_q || f_fit) ? S_DONE : S_MSCAN;
      S_MSCAN: if (last) st_d = S_DONE;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_st = ST_OK;
    res_blk = '0;
    f_wr = 1'b0;
    f_drop = 1'b0;
    m_wr = 1'b0;
    m_idx = mfound_q ? mslot_q : mcnt_q[IdxW-1:0];
    if (cmd_q) begin
      if (!mfound_q) begin
        res_st = ST_NOT_FOUND;
      end else if (fcnt_q == PgW'(MaxPages)) begin
        res_st = ST_LIST_FULL;
      end else begin
        res_blk = mhit_q;
        f_wr = done;
      end
    end else if (ffound_q) begin
      res_blk = fhit_q;
      f_drop = done;
    end else if (hw_sum > (PgW+1)'(MaxPages) ||
                 (!mfound_q && mcnt_q == PgW'(MaxPages))) begin
      res_st = ST_NO_MEM;
    end else begin
      res_blk.start = hw_q;
      res_blk.pages = npg_q;
      m_wr = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; psl_q <= CfgW'(8); fcnt_q <= '0; mcnt_q <= '0; hw_q <= '0;
      outst_q <= '0; ov_q <= 1'b0; rs_q <= ST_OK; rb_q <= '0; roff_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) psl_q <= cfg_data_i;
      if (done) begin
        ov_q <= 1'b1;
        rs_q <= res_st;
        rb_q <= res_blk;
        roff_q <= page_addr(res_blk.start, psl_q);
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (f_wr) begin
        fcnt_q <= fcnt_q + 1'b1; outst_q <= outst_q - 1'b1;
      end else if (f_drop) begin
        fcnt_q <= fcnt_q - 1'b1; outst_q <= outst_q + 1'b1;
      end else if (m_wr) begin
        hw_q <= hw_sum[PgW-1:0]; outst_q <= outst_q + 1'b1;
        if (!mfound_q) mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= cmd_i; addr_q <= byte_address_i; npg_q <= npg_in;
      i_q <= '0; ffound_q <= 1'b0; mfound_q <= 1'b0;
    end else if (st_q == S_FSCAN || st_q == S_MSCAN) begin
      i_q <= i_q + 1'b1;
      if (f_fit) begin
        ffound_q <= 1'b1; fslot_q <= i_q; fhit_q <= fhead;
      end
      if (m_hit) begin
        mfound_q <= 1'b1; mslot_q <= i_q; mhit_q <= mhead;
      end
    end
  end

  pffa_chain u_free (
    .clk_i, .rot_i(st_q == S_FSCAN), .drop_i(f_drop), .drop_idx_i(fslot_q),
    .wr_i(f_wr), .wr_idx_i(fcnt_q[IdxW-1:0]), .wr_data_i(mhit_q), .head_o(fhead)
  );
  pffa_chain u_map (
    .clk_i, .rot_i(st_q == S_MSCAN), .drop_i(1'b0), .drop_idx_i('0),
    .wr_i(m_wr), .wr_idx_i(m_idx), .wr_data_i(res_blk), .head_o(mhead)
  );

  assign out_valid_o = ov_q;
  assign status_o = rs_q;
  assign start_page_o = rb_q.start;
  assign pages_granted_o = rb_q.pages;
  assign block_offset_o = roff_q;
  assign outstanding_o = outst_q;
endmodule
`default_nettype wire

// ===== rtl/core/pffa_checker.sv =====
// Port checker for the paged first-fit allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pffa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic [pffa_pkg::AddrW-1:0] block_offset_o,
  input wire logic [pffa_pkg::PgW-1:0] start_page_o,
  input wire logic [pffa_pkg::PgW-1:0] pages_granted_o
);
  import pffa_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({status_o, block_offset_o, start_page_o, pages_granted_o}))
    else $error("stalled result changed");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      block_offset_o == '0 && start_page_o == '0 && pages_granted_o == '0)
    else $error("failed result carries block");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request taken");
endmodule
bind paged_first_fit_allocator pffa_checker u_chk (.*);
`default_nettype wire

// ===== verif/paged_first_fit_allocator_tb.sv =====
// Testbench for the paged first-fit allocator: predicted results checked against DUT output.
`timescale 1ns / 1ps
module paged_first_fit_allocator_tb;
  import pffa_pkg::*;

  localparam int CycleLimit = 5000000;
  localparam int DrainCycles = 600;

  typedef struct {
    logic             cmd;
    logic [NbW-1:0]   nbytes;
    logic [AddrW-1:0] baddr;
  } request_t;

  typedef struct {
    status_e          status;
    logic [AddrW-1:0] offset;
    logic [PgW-1:0]   start;
    logic [PgW-1:0]   pages;
    logic [OutW-1:0]  outs;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [NbW-1:0] num_bytes_i = '0;
  logic [AddrW-1:0] byte_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [AddrW-1:0] block_offset_o;
  logic [PgW-1:0] start_page_o;
  logic [PgW-1:0] pages_granted_o;
  logic signed [OutW-1:0] outstanding_o;

  paged_first_fit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .cmd_i(cmd_i),
    .num_bytes_i(num_bytes_i), .byte_address_i(byte_address_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
    .block_offset_o(block_offset_o), .start_page_o(start_page_o),
    .pages_granted_o(pages_granted_o), .outstanding_o(outstanding_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  request_t pending_q[$];
  grant_t   grant_q[$];
  int       mismatches = 0;
  int       cycles = 0;

  // allocator state mirror
  logic [CfgW-1:0] shift_cfg;
  logic [PgW-1:0]  fl_start[MaxPages];
  logic [PgW-1:0]  fl_pages[MaxPages];
  int              fl_cnt;
  int              hw_page;
  logic [PgW-1:0]  map_start[MaxPages];
  logic [PgW-1:0]  map_pages[MaxPages];
  int              map_cnt;
  logic [OutW-1:0] outs_cnt;

  function automatic longint unsigned byte_of(input logic [PgW-1:0] pg);
    return longint'(pg) << shift_cfg;
  endfunction

  function automatic grant_t make_grant(input status_e s, input logic [PgW-1:0] st,
                                        input logic [PgW-1:0] pg);
    grant_t g;
    longint unsigned a;
    a = byte_of(st);
    g.status = s;
    g.offset = (s == ST_OK) ? a[AddrW-1:0] : '0;
    g.start = (s == ST_OK) ? st : '0;
    g.pages = (s == ST_OK) ? pg : '0;
    g.outs = outs_cnt;
    return g;
  endfunction

  function automatic grant_t predict_alloc(input logic [NbW-1:0] nb);
    longint unsigned np;
    logic [PgW-1:0] st;
    logic [PgW-1:0] pg;
    int slot;
    np = (longint'(nb) + ((64'd1 << shift_cfg) - 1)) >> shift_cfg;
    for (int i = 0; i < fl_cnt; i++) begin
      if (longint'(fl_pages[i]) >= np) begin
        st = fl_start[i];
        pg = fl_pages[i];
        for (int j = i + 1; j < fl_cnt; j++) begin
          fl_start[j-1] = fl_start[j];
          fl_pages[j-1] = fl_pages[j];
        end
        fl_cnt--;
        outs_cnt++;
        return make_grant(ST_OK, st, pg);
      end
    end
    if (longint'(hw_page) + np > MaxPages) return make_grant(ST_NO_MEM, '0, '0);
    st = hw_page[PgW-1:0];
    slot = map_cnt;
    for (int i = 0; i < map_cnt; i++) begin
      if (byte_of(map_start[i]) == byte_of(st)) begin
        slot = i;
        break;
      end
    end
    if (slot >= MaxPages) return make_grant(ST_NO_MEM, '0, '0);
    map_start[slot] = st;
    map_pages[slot] = np[PgW-1:0];
    if (slot == map_cnt) map_cnt++;
    hw_page = hw_page + int'(np);
    outs_cnt++;
    return make_grant(ST_OK, st, np[PgW-1:0]);
  endfunction

  function automatic grant_t predict_free(input logic [AddrW-1:0] ba);
    for (int i = 0; i < map_cnt; i++) begin
      if (byte_of(map_start[i]) == longint'(ba)) begin
        if (fl_cnt >= MaxPages) return make_grant(ST_LIST_FULL, '0, '0);
        fl_start[fl_cnt] = map_start[i];
        fl_pages[fl_cnt] = map_pages[i];
        fl_cnt++;
        outs_cnt--;
        return make_grant(ST_OK, map_start[i], map_pages[i]);
      end
    end
    return make_grant(ST_NOT_FOUND, '0, '0);
  endfunction

  task automatic push_request(input logic c, input logic [NbW-1:0] nb,
                              input logic [AddrW-1:0] ba);
    request_t r;
    r.cmd = c;
    r.nbytes = nb;
    r.baddr = ba;
    pending_q.push_back(r);
    grant_q.push_back(c ? predict_free(ba) : predict_alloc(nb));
  endtask

  function automatic logic [AddrW-1:0] mapped_addr();
    longint unsigned a;
    a = byte_of(map_start[$urandom_range(0, map_cnt - 1)]);
    return a[AddrW-1:0];
  endfunction

  task automatic random_requests(input int n);
    int r;
    logic [NbW-1:0] nb;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        nb = (shift_cfg <= 21) ? NbW'($urandom_range(0, 4 << shift_cfg)) : NbW'($urandom);
        push_request(1'b0, nb, AddrW'($urandom));
      end else if (r < 85 && map_cnt > 0) begin
        push_request(1'b1, NbW'($urandom), mapped_addr());
      end else begin
        push_request(1'($urandom_range(0, 1)), NbW'($urandom),
                     ($urandom_range(0, 3) == 0) ? AddrW'(1 << NbW) : AddrW'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || grant_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_page_size(input logic [CfgW-1:0] v);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shift_cfg = v;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  int in_gap = 0;
  int in_calm = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        r = pending_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= r.cmd;
        num_bytes_i <= r.nbytes;
        byte_address_i <= r.baddr;
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(0, 19) == 0) in_calm = $urandom_range(10, 30);
        else in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[paged_first_fit_allocator] ERROR");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d", status_o);
        end else begin
          g = grant_q.pop_front();
          if (status_o !== g.status || block_offset_o !== g.offset ||
              start_page_o !== g.start || pages_granted_o !== g.pages ||
              outstanding_o !== g.outs) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch exp st=%0d off=%h pg0=%0d n=%0d out=%0d",
                     g.status, g.offset, g.start, g.pages, $signed(g.outs));
              $display(" got st=%0d off=%h pg0=%0d n=%0d out=%0d", status_o,
                       block_offset_o, start_page_o, pages_granted_o, outstanding_o);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    shift_cfg = 5'd8;
    fl_cnt = 0;
    hw_page = 0;
    map_cnt = 0;
    outs_cnt = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(1'b0, 24'd0, '0);
    push_request(1'b0, 24'd1, '0);
    push_request(1'b0, 24'hFFFFFF, '0);
    push_request(1'b1, '0, 25'd0);
    push_request(1'b1, 24'hFFFFFF, 25'd0);
    push_request(1'b1, '0, 25'd12345);
    push_request(1'b1, '0, 25'h1000000);
    push_request(1'b1, '0, 25'h1FFFFFF);
    push_request(1'b0, 24'd0, '0);
    push_request(1'b0, 24'd256, '0);

    while (hw_page < MaxPages) push_request(1'b0, NbW'($urandom_range(1, 256)), AddrW'($urandom));
    push_request(1'b0, 24'd0, '0);
    push_request(1'b0, 24'd200, '0);
    for (int k = 0; k <= MaxPages; k++) push_request(1'b1, NbW'($urandom), 25'd0);
    random_requests(150);

    write_page_size(5'd31);
    random_requests(40);
    write_page_size(5'd16);
    random_requests(40);
    write_page_size(5'd4);
    random_requests(60);
    write_page_size(5'd0);
    random_requests(40);
    write_page_size(5'd8);
    random_requests(60);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("[paged_first_fit_allocator] OK");
    end else begin
      $display("[paged_first_fit_allocator] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/pffa_pkg.sv
rtl/core/pffa_cell.sv
rtl/core/pffa_chain.sv
rtl/core/paged_first_fit_allocator.sv
rtl/core/pffa_checker.sv
verif/paged_first_fit_allocator_tb.sv
